// ===== hdl/anem_pkg.sv =====
// shared types and constants of the anemometer speed meter
`default_nettype none
package anem_pkg;

  // field widths
  localparam int unsigned LockoutW = 10;
  localparam int unsigned TimeoutW = 16;
  localparam int unsigned CircW    = 12;
  localparam int unsigned CountW   = 16;
  localparam int unsigned MmW      = 22;
  localparam int unsigned CkW      = 21;
  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 16;

  // divider walks the wider dividend one bit per cycle
  localparam int unsigned DivSteps = MmW;
  localparam int unsigned StepW    = $clog2(DivSteps);

  // reset values and scale factors
  localparam logic [LockoutW-1:0] LockoutReset = LockoutW'(25);
  localparam logic [TimeoutW-1:0] TimeoutReset = TimeoutW'(4000);
  localparam logic [CircW-1:0]    CircReset    = CircW'(314);
  localparam logic [CountW-1:0]   PeriodReset  = CountW'(5000);
  localparam logic [CountW-1:0]   ElapsedMax   = {CountW{1'b1}};
  localparam logic [MmW-1:0]      MmScale      = MmW'(1000);
  localparam logic [CkW-1:0]      CkScale      = CkW'(360);

  // configuration register indexes
  typedef enum logic [CfgIdxW-1:0] {
    CfgLockout = 2'd0,
    CfgTimeout = 2'd1,
    CfgCircum  = 2'd2
  } cfg_idx_e;

  // controller states
  typedef enum logic [1:0] {
    StIdle,
    StDiv,
    StOut
  } state_e;

  // controller to datapath
  typedef struct packed {
    logic load;   // take a tick, update counters, start division
    logic step;   // one division step
    logic store;  // copy quotients into the output register
  } dp_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic div_last;  // this step is the last division step
  } dp_stat_t;

endpackage
`default_nettype wire

// ===== hdl/anem_ctrl.sv =====
// controller state machine of the anemometer speed meter
`default_nettype none
module anem_ctrl import anem_pkg::*; (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     in_valid_i,
  output logic          in_ready_o,
  output logic          out_valid_o,
  input  wire logic     out_ready_i,
  input  wire dp_stat_t stat_i,
  output dp_cmd_t       cmd_o
);

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   out_free;

  assign out_free = !out_valid_q || out_ready_i;

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      StIdle: if (in_valid_i) state_d = StDiv;
      StDiv:  if (stat_i.div_last) state_d = StOut;
      StOut:  if (out_free) state_d = StIdle;
      default: state_d = StIdle;
    endcase
  end

  // outputs
  always_comb begin
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      StIdle: begin
        in_ready_o = 1'b1;
        cmd_o.load = in_valid_i;
      end
      StDiv: cmd_o.step = 1'b1;
      StOut: cmd_o.store = out_free;
      default: cmd_o = '0;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.store) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  assign out_valid_o = out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule
`default_nettype wire

// ===== hdl/anem_dp.sv =====
// datapath of the anemometer speed meter: registers, counters, divider, output
`default_nettype none
module anem_dp import anem_pkg::*; (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                cfg_we_i,
  input  wire logic [CfgIdxW-1:0]  cfg_index_i,
  input  wire logic [CfgDataW-1:0] cfg_data_i,
  input  wire logic                pulse_edge_i,
  input  wire dp_cmd_t             cmd_i,
  output dp_stat_t                 stat_o,
  output logic [MmW-1:0]           speed_mm_per_s_o,
  output logic [CkW-1:0]           speed_centi_kmh_o
);

  logic [LockoutW-1:0] lockout_q;
  logic [TimeoutW-1:0] timeout_q;
  logic [CircW-1:0]    circ_q;
  logic [CountW-1:0]   elapsed_q, elapsed_d;
  logic [CountW-1:0]   period_q, period_d;
  logic [CountW-1:0]   elapsed_inc;
  logic                edge_ok;

  logic [CountW-1:0]   div_q;
  logic                zero_q;
  logic [StepW-1:0]    step_q;
  logic [MmW-1:0]      num_mm_q, num_ck_q;
  logic [CountW-1:0]   rem_mm_q, rem_ck_q;
  logic [MmW-1:0]      mm_prod;
  logic [CkW-1:0]      ck_prod;

  logic [CountW:0]     r_mm, r_ck, s_mm, s_ck;
  logic                ge_mm, ge_ck;

  logic [MmW-1:0]      mm_out_q;
  logic [CkW-1:0]      ck_out_q;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lockout_q <= LockoutReset;
      timeout_q <= TimeoutReset;
      circ_q    <= CircReset;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_index_i))
        CfgLockout: lockout_q <= cfg_data_i[LockoutW-1:0];
        CfgTimeout: timeout_q <= cfg_data_i[TimeoutW-1:0];
        CfgCircum:  circ_q    <= cfg_data_i[CircW-1:0];
        default: ;
      endcase
    end
  end

  // tick update: saturating count, lockout check
  assign elapsed_inc = (elapsed_q == ElapsedMax) ? elapsed_q : elapsed_q + CountW'(1);
  assign edge_ok     = pulse_edge_i && (elapsed_inc > CountW'(lockout_q));

  always_comb begin
    elapsed_d = elapsed_inc;
    period_d  = period_q;
    if (edge_ok) begin
      period_d  = elapsed_inc;
      elapsed_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      elapsed_q <= '0;
      period_q  <= PeriodReset;
    end else if (cmd_i.load) begin
      elapsed_q <= elapsed_d;
      period_q  <= period_d;
    end
  end

  // dividends, constant multiplies
  assign mm_prod = MmW'(circ_q) * MmScale;
  assign ck_prod = CkW'(circ_q) * CkScale;

  // restoring division, both quotients share the divisor
  assign r_mm  = {rem_mm_q, num_mm_q[MmW-1]};
  assign r_ck  = {rem_ck_q, num_ck_q[MmW-1]};
  assign ge_mm = r_mm >= {1'b0, div_q};
  assign ge_ck = r_ck >= {1'b0, div_q};
  assign s_mm  = r_mm - {1'b0, div_q};
  assign s_ck  = r_ck - {1'b0, div_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q <= '0;
    end else if (cmd_i.load) begin
      step_q <= '0;
    end else if (cmd_i.step) begin
      step_q <= step_q + StepW'(1);
    end
  end

  assign stat_o.div_last = cmd_i.step && (step_q == StepW'(DivSteps - 1));

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      div_q    <= (period_d == '0) ? CountW'(1) : period_d;
      zero_q   <= elapsed_d > timeout_q;
      num_mm_q <= mm_prod;
      num_ck_q <= MmW'(ck_prod);
      rem_mm_q <= '0;
      rem_ck_q <= '0;
    end else if (cmd_i.step) begin
      num_mm_q <= {num_mm_q[MmW-2:0], ge_mm};
      num_ck_q <= {num_ck_q[MmW-2:0], ge_ck};
      rem_mm_q <= ge_mm ? s_mm[CountW-1:0] : r_mm[CountW-1:0];
      rem_ck_q <= ge_ck ? s_ck[CountW-1:0] : r_ck[CountW-1:0];
    end
  end

  // output register, zero after timeout
  always_ff @(posedge clk_i) begin
    if (cmd_i.store) begin
      mm_out_q <= zero_q ? '0 : num_mm_q;
      ck_out_q <= zero_q ? '0 : num_ck_q[CkW-1:0];
    end
  end

  assign speed_mm_per_s_o  = mm_out_q;
  assign speed_centi_kmh_o = ck_out_q;

endmodule
`default_nettype wire

// ===== hdl/anemometer_speed_meter_top.sv =====
// top level of the anemometer speed meter
//
// usage
// - input channel: one transfer per millisecond tick, pulse_edge_i set when
//   the anemometer showed a rising edge during that millisecond
// - output channel: one transfer per tick, speed in mm/s and in hundredths
//   of km/h, both zero once no edge was taken for longer than the timeout
// - config channel: cfg_index_i selects lockout (0), timeout (1) or
//   circumference (2); other indexes are dropped; cfg_ready_o is always high;
//   write only while no tick is in flight
// - divider: an input transfer starts the shared restoring divider, which
//   retires one quotient bit per cycle over 22 steps; the store state then
//   copies the quotients into the output register
// - a new tick is taken only once the previous one has been stored
// - the output register holds a finished result, so the next tick is taken
//   while that result still waits; a stalled receiver holds the block in its
//   store state until the register frees up
// - reset: registers return to lockout 25, timeout 4000, circumference 314,
//   elapsed count 0 and period 5000; no result is pending
`default_nettype none
module anemometer_speed_meter_top import anem_pkg::*; (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                in_valid_i,
  output logic                     in_ready_o,
  input  wire logic                pulse_edge_i,
  output logic                     out_valid_o,
  input  wire logic                out_ready_i,
  output logic [MmW-1:0]           speed_mm_per_s_o,
  output logic [CkW-1:0]           speed_centi_kmh_o,
  input  wire logic                cfg_valid_i,
  output logic                     cfg_ready_o,
  input  wire logic [CfgIdxW-1:0]  cfg_index_i,
  input  wire logic [CfgDataW-1:0] cfg_data_i
);

  dp_cmd_t  cmd;
  dp_stat_t stat;

  // config writes are always taken
  assign cfg_ready_o = 1'b1;

  // sequencer: idle, divide, store
  anem_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  // registers, tick counters, divider and output register
  anem_dp u_dp (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cfg_we_i          (cfg_valid_i),
    .cfg_index_i       (cfg_index_i),
    .cfg_data_i        (cfg_data_i),
    .pulse_edge_i      (pulse_edge_i),
    .cmd_i             (cmd),
    .stat_o            (stat),
    .speed_mm_per_s_o  (speed_mm_per_s_o),
    .speed_centi_kmh_o (speed_centi_kmh_o)
  );

endmodule
`default_nettype wire

// ===== hdl/anem_chk.sv =====
// port level checks of the anemometer speed meter and their bind
`default_nettype none
module anem_chk import anem_pkg::*; (
  input wire logic                clk_i,
  input wire logic                rst_ni,
  input wire logic                in_valid_i,
  input wire logic                in_ready_o,
  input wire logic                out_valid_o,
  input wire logic                out_ready_i,
  input wire logic [MmW-1:0]      speed_mm_per_s_o,
  input wire logic [CkW-1:0]      speed_centi_kmh_o
);

  // one tick at a time: ready drops after an input transfer
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("input ready stayed high after a transfer");

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(speed_mm_per_s_o)
      && $stable(speed_centi_kmh_o))
    else $error("stalled result changed");

  // km/h figure is 0.36 of the mm/s figure, never above it
  a_units_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> speed_centi_kmh_o <= CkW'(speed_mm_per_s_o >> 1)
      || speed_centi_kmh_o <= speed_mm_per_s_o[CkW-1:0] && speed_mm_per_s_o < MmW'(2))
    else $error("speed units disagree");

  // largest circumference over the shortest period bounds the result
  a_mm_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> speed_mm_per_s_o <= MmW'(4095000))
    else $error("speed out of range");

endmodule

bind anemometer_speed_meter_top anem_chk u_anem_chk (
  .clk_i             (clk_i),
  .rst_ni            (rst_ni),
  .in_valid_i        (in_valid_i),
  .in_ready_o        (in_ready_o),
  .out_valid_o       (out_valid_o),
  .out_ready_i       (out_ready_i),
  .speed_mm_per_s_o  (speed_mm_per_s_o),
  .speed_centi_kmh_o (speed_centi_kmh_o)
);
`default_nettype wire

// ===== tb/sv/tb_top.sv =====
// self-checking testbench for the anemometer speed meter: directed table, random pulse trains
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import anem_pkg::*;

  // index with no register behind it, writes there must be dropped
  localparam logic [CfgIdxW-1:0] CfgSpare = 2'd3;
  // generous cycle budget, well above the worst mix of idling and stalls
  localparam int unsigned CycleLimit = 600_000;
  localparam int unsigned RandPhases = 10;
  localparam int unsigned PhaseTicks = 125;

  typedef struct packed {
    logic [MmW-1:0] mm;
    logic [CkW-1:0] ck;
  } speed_t;

  typedef enum bit {RowTick, RowCfg} row_kind_e;

  typedef struct packed {
    row_kind_e             kind;
    logic [CfgIdxW-1:0]    idx;
    logic [CfgDataW-1:0]   data;
    logic                  pulse;
    logic                  typed;   // expected speeds given in the row
    logic [MmW-1:0]        mm;
    logic [CkW-1:0]        ck;
  } dir_row_t;

  // directed table: config writes and ticks in order
  // rows with typed set carry speeds read straight off the spec, the rest go
  // through the predictor
  localparam int unsigned DirLen = 30;
  localparam dir_row_t DirRows [DirLen] = '{
    // right after reset: period 5000, circumference 314
    '{kind: RowTick, pulse: 1'b0, typed: 1'b1, mm: 22'd62, ck: 21'd22, default: '0},
    // edge inside the reset lockout is ignored
    '{kind: RowTick, pulse: 1'b1, typed: 1'b1, mm: 22'd62, ck: 21'd22, default: '0},
    // lockout 0, upper data bits must be masked off
    '{kind: RowCfg, idx: CfgLockout, data: 16'hFC00, default: '0},
    '{kind: RowTick, pulse: 1'b1, typed: 1'b1, mm: 22'd104666, ck: 21'd37680, default: '0},
    // shortest possible period
    '{kind: RowTick, pulse: 1'b1, typed: 1'b1, mm: 22'd314000, ck: 21'd113040, default: '0},
    // largest circumference and timeout
    '{kind: RowCfg, idx: CfgCircum, data: 16'hFFFF, default: '0},
    '{kind: RowCfg, idx: CfgTimeout, data: 16'hFFFF, default: '0},
    '{kind: RowTick, pulse: 1'b1, typed: 1'b1, mm: 22'd4095000, ck: 21'd1474200,
      default: '0},
    '{kind: RowTick, pulse: 1'b0, typed: 1'b1, mm: 22'd4095000, ck: 21'd1474200,
      default: '0},
    // zero circumference gives zero speed
    '{kind: RowCfg, idx: CfgCircum, data: 16'hF000, default: '0},
    '{kind: RowTick, pulse: 1'b1, typed: 1'b1, mm: 22'd0, ck: 21'd0, default: '0},
    '{kind: RowCfg, idx: CfgCircum, data: 16'd314, default: '0},
    // timeout zero: only a tick that takes an edge shows a speed
    '{kind: RowCfg, idx: CfgTimeout, data: 16'h0000, default: '0},
    '{kind: RowTick, pulse: 1'b0, typed: 1'b1, mm: 22'd0, ck: 21'd0, default: '0},
    '{kind: RowTick, pulse: 1'b1, typed: 1'b1, mm: 22'd157000, ck: 21'd56520, default: '0},
    // unknown index must not touch any register
    '{kind: RowCfg, idx: CfgSpare, data: 16'hFFFF, default: '0},
    '{kind: RowTick, pulse: 1'b0, typed: 1'b1, mm: 22'd0, ck: 21'd0, default: '0},
    // lockout and timeout boundaries, one tick either side
    '{kind: RowCfg, idx: CfgLockout, data: 16'd2, default: '0},
    '{kind: RowCfg, idx: CfgTimeout, data: 16'd3, default: '0},
    '{kind: RowTick, pulse: 1'b1, default: '0},
    '{kind: RowTick, pulse: 1'b1, default: '0},
    '{kind: RowTick, pulse: 1'b0, default: '0},
    '{kind: RowTick, pulse: 1'b0, default: '0},
    '{kind: RowTick, pulse: 1'b0, default: '0},
    '{kind: RowTick, pulse: 1'b0, default: '0},
    '{kind: RowTick, pulse: 1'b1, default: '0},
    // largest lockout
    '{kind: RowCfg, idx: CfgLockout, data: 16'h03FF, default: '0},
    '{kind: RowCfg, idx: CfgTimeout, data: 16'd4000, default: '0},
    '{kind: RowTick, pulse: 1'b1, default: '0},
    '{kind: RowTick, pulse: 1'b0, default: '0}
  };

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                in_valid_i = 1'b0;
  logic                in_ready_o;
  logic                pulse_edge_i = 1'b0;
  logic                out_valid_o;
  logic                out_ready_i = 1'b0;
  logic [MmW-1:0]      speed_mm_per_s_o;
  logic [CkW-1:0]      speed_centi_kmh_o;
  logic                cfg_valid_i = 1'b0;
  logic                cfg_ready_o;
  logic [CfgIdxW-1:0]  cfg_index_i = CfgLockout;
  logic [CfgDataW-1:0] cfg_data_i = '0;

  // predictor state and its copy of the registers
  logic [CountW-1:0]   ms_since_edge = '0;
  logic [CountW-1:0]   pulse_period = PeriodReset;
  logic [LockoutW-1:0] lockout_cfg = LockoutReset;
  logic [TimeoutW-1:0] timeout_cfg = TimeoutReset;
  logic [CircW-1:0]    circ_cfg = CircReset;

  speed_t      expected_speed_q [$];
  speed_t      head_speed;
  int unsigned mismatch_cnt = 0;
  int unsigned cycle_cnt = 0;
  int unsigned ticks_sent = 0;
  bit          calm = 1'b0;   // no idling on either side while set

  anemometer_speed_meter_top dut (
    .clk_i,
    .rst_ni,
    .in_valid_i,
    .in_ready_o,
    .pulse_edge_i,
    .out_valid_o,
    .out_ready_i,
    .speed_mm_per_s_o,
    .speed_centi_kmh_o,
    .cfg_valid_i,
    .cfg_ready_o,
    .cfg_index_i,
    .cfg_data_i
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // run limit, a hang counts as a failure
  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CycleLimit) begin
      $display("Some tests failed");
      $finish;
    end
  end

  // one millisecond tick of the meter: bump the count, maybe take the edge,
  // then derive both speeds from the stored period
  function automatic speed_t tick_speed(bit pe);
    speed_t     s;
    logic [63:0] divisor;
    s = '0;
    if (ms_since_edge != ElapsedMax) ms_since_edge = ms_since_edge + 1'b1;
    if (pe && ms_since_edge > CountW'(lockout_cfg)) begin
      pulse_period  = ms_since_edge;
      ms_since_edge = '0;
    end
    if (ms_since_edge <= timeout_cfg) begin
      // a stored period is never zero, guard it anyway
      divisor = (pulse_period == '0) ? 64'd1 : 64'(pulse_period);
      s.mm = MmW'((64'(circ_cfg) * 64'(MmScale)) / divisor);
      s.ck = CkW'((64'(circ_cfg) * 64'(CkScale)) / divisor);
    end
    return s;
  endfunction

  function automatic void flag_mismatch(string msg);
    mismatch_cnt++;
    if (mismatch_cnt <= 10) $display("mismatch: %s", msg);
  endfunction

  // present one tick, hold it until the transfer, then log its expected speeds
  task automatic send_tick(input bit pe, input bit typed = 1'b0,
                           input speed_t typed_speed = '0);
    speed_t predicted;
    // a config write may still be standing from the step before
    cfg_valid_i <= 1'b0;
    if (!calm && $urandom_range(0, 99) < 26) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 40)) @(posedge clk_i);
    end
    in_valid_i   <= 1'b1;
    pulse_edge_i <= pe;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    predicted = tick_speed(pe);
    expected_speed_q.push_back(typed ? typed_speed : predicted);
    ticks_sent++;
  endtask

  // stop sending and wait for every outstanding result
  task automatic settle_ticks();
    in_valid_i <= 1'b0;
    while (expected_speed_q.size() != 0) @(posedge clk_i);
  endtask

  // register write, only ever issued with the meter idle
  task automatic write_reg(input logic [CfgIdxW-1:0] idx,
                           input logic [CfgDataW-1:0] data);
    settle_ticks();
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    case (idx)
      CfgLockout: lockout_cfg = data[LockoutW-1:0];
      CfgTimeout: timeout_cfg = data[TimeoutW-1:0];
      CfgCircum:  circ_cfg = data[CircW-1:0];
      default: ;
    endcase
  endtask

  // receiver: random stalls, compare each transfer with the oldest expectation
  always @(posedge clk_i) begin
    out_ready_i <= calm || ($urandom_range(0, 99) >= 26);
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (expected_speed_q.size() == 0) begin
        flag_mismatch($sformatf("unexpected result mm/s %0d centi-km/h %0d",
                                speed_mm_per_s_o, speed_centi_kmh_o));
      end else begin
        head_speed = expected_speed_q.pop_front();
        if (speed_mm_per_s_o !== head_speed.mm)
          flag_mismatch($sformatf("speed_mm_per_s expected %0d got %0d",
                                  head_speed.mm, speed_mm_per_s_o));
        if (speed_centi_kmh_o !== head_speed.ck)
          flag_mismatch($sformatf("speed_centi_kmh expected %0d got %0d",
                                  head_speed.ck, speed_centi_kmh_o));
      end
    end
  end

  initial begin
    int unsigned ph;
    int unsigned phase_end;
    int unsigned chunk;
    int unsigned mode;
    int unsigned lo;
    int unsigned to;
    int unsigned ci;
    int          gap;
    int          quiet_max;
    logic [CfgDataW-1:0] data;

    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed table
    foreach (DirRows[i]) begin
      if (DirRows[i].kind == RowCfg)
        write_reg(DirRows[i].idx, DirRows[i].data);
      else
        send_tick(DirRows[i].pulse, DirRows[i].typed,
                  speed_t'({DirRows[i].mm, DirRows[i].ck}));
    end

    // random phases, each with its own register setting
    for (ph = 0; ph < RandPhases; ph++) begin
      case (ph)
        0: begin
          lo = 0; to = 1; ci = 1;
        end
        1: begin
          lo = 1023; to = 65535; ci = 4095;
        end
        default: begin
          case ($urandom_range(0, 3))
            0: lo = 0;
            1: lo = $urandom_range(0, 8);
            default: lo = $urandom_range(0, 40);
          endcase
          case ($urandom_range(0, 4))
            0: to = 0;
            1: to = 65535;
            4: to = $urandom_range(0, 65535);
            default: to = $urandom_range(1, 60);
          endcase
          case ($urandom_range(0, 4))
            0: ci = 0;
            1: ci = 4095;
            default: ci = $urandom_range(1, 4095);
          endcase
        end
      endcase
      // unused upper data bits get random values, the block must drop them
      data = CfgDataW'($urandom);
      data[LockoutW-1:0] = LockoutW'(lo);
      write_reg(CfgLockout, data);
      write_reg(CfgTimeout, TimeoutW'(to));
      data = CfgDataW'($urandom);
      data[CircW-1:0] = CircW'(ci);
      write_reg(CfgCircum, data);
      if ($urandom_range(0, 3) == 0) write_reg(CfgSpare, CfgDataW'($urandom));

      calm = (ph == 3);
      phase_end = ticks_sent + PhaseTicks;
      chunk = 0;
      while (ticks_sent < phase_end) begin
        // one phase holds the sender back until the pipe is empty
        if (ph == 6 && chunk == 4) settle_ticks();
        chunk++;
        mode = $urandom_range(0, 99);
        if (mode < 70) begin
          // regular pulse train, spacing close to the lockout on both sides
          gap = int'(lockout_cfg) + int'($urandom_range(0, 10)) -
                int'($urandom_range(0, 6));
          if (gap < 0) gap = 0;
          // keep the phase close to its tick count
          if (gap > int'(phase_end - ticks_sent)) gap = int'(phase_end - ticks_sent);
          repeat (gap) send_tick(1'b0);
          send_tick(1'b1);
        end else if (mode < 85) begin
          // contact bounce: random edges
          repeat (6) send_tick(1'($urandom_range(0, 1)));
        end else begin
          // calm air, at times long enough to run past a short timeout
          quiet_max = int'(timeout_cfg) + 4;
          if (quiet_max > 150) quiet_max = 150;
          if (quiet_max > int'(phase_end - ticks_sent))
            quiet_max = int'(phase_end - ticks_sent);
          repeat ($urandom_range(1, quiet_max)) send_tick(1'b0);
        end
      end
    end
    calm = 1'b0;

    // drain, then give stray results time to show up
    settle_ticks();
    repeat (40) @(posedge clk_i);
    if (mismatch_cnt == 0)
      $display("All tests passed");
    else
      $display("Some tests failed");
    $finish;
  end

endmodule

// ===== anemometer_speed_meter_top.f =====
hdl/anem_pkg.sv
hdl/anem_ctrl.sv
hdl/anem_dp.sv
hdl/anemometer_speed_meter_top.sv
hdl/anem_chk.sv
tb/sv/tb_top.sv
